>>> hdl/rss_pkg.sv
`timescale 1ns / 1ps

package rss_pkg;

    localparam int SPAN_W     = 12;
    localparam int COLOR_W    = 8;
    localparam int ERR_W      = 14;
    localparam int LEN_W      = 13;
    localparam int MAX_RUN    = 64;
    localparam int LEFT_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = 12;
    localparam int DIV_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_SPAN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_SPAN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd2;

    localparam logic [SPAN_W-1:0]  RST_DEST_SPAN   = 12'd4;
    localparam logic [SPAN_W-1:0]  RST_SRC_SPAN    = 12'd2;
    localparam logic [COLOR_W-1:0] RST_TRANSPARENT = 8'd255;

    // Output tdata layout, lowest bit first.
    localparam int OUT_TDATA_W = 24;
    localparam int OB_COLOR_LO = 0;
    localparam int OB_WE       = 8;
    localparam int OB_X_LO     = 9;
    localparam int OB_RUN_LAST = 21;
    localparam int OB_CLIPPED  = 22;

    typedef struct packed {
        logic take_in;
        logic div_start;
        logic calc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic line_start;
        logic span_short;
        logic div_done;
        logic left_zero;
        logic left_one;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/rss_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module rss_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rss_pkg::SPAN_W-1:0]     i_dividend,
    input  logic [rss_pkg::SPAN_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [rss_pkg::SPAN_W-1:0]     o_quot,
    output logic [rss_pkg::SPAN_W-1:0]     o_rem
);

    logic                              r_busy;
    logic                              r_done;
    logic [rss_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [rss_pkg::SPAN_W-1:0]        r_q;
    logic [rss_pkg::SPAN_W-1:0]        r_rem;
    logic [rss_pkg::SPAN_W-1:0]        r_dvs;

    logic [rss_pkg::SPAN_W:0]          shifted;
    logic [rss_pkg::SPAN_W+1:0]        diff;

    always_comb begin
        shifted = {r_rem, r_q[rss_pkg::SPAN_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rss_pkg::DIV_CNT_W'(rss_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[rss_pkg::SPAN_W+1]) begin
                r_rem <= diff[rss_pkg::SPAN_W-1:0];
                r_q   <= {r_q[rss_pkg::SPAN_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[rss_pkg::SPAN_W-1:0];
                r_q   <= {r_q[rss_pkg::SPAN_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

>>> hdl/rss_dp.sv
`timescale 1ns / 1ps

module rss_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [rss_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [rss_pkg::SPAN_W-1:0]         i_cfg_wdata,
    input  logic [rss_pkg::COLOR_W-1:0]        i_in_color,
    input  rss_pkg::t_cmd                      i_cmd,
    output rss_pkg::t_sts                      o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [rss_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                               o_out_last
);

    // Configuration registers.
    logic [rss_pkg::SPAN_W-1:0]   r_dest_span;
    logic [rss_pkg::SPAN_W-1:0]   r_src_span;
    logic [rss_pkg::COLOR_W-1:0]  r_transp;

    // Line state.
    logic [rss_pkg::ERR_W-1:0]    r_err;
    logic [rss_pkg::SPAN_W-1:0]   r_src_idx;
    logic [rss_pkg::SPAN_W-1:0]   r_dest_pos;
    logic [rss_pkg::SPAN_W-1:0]   r_whole;
    logic [rss_pkg::SPAN_W-1:0]   r_rem;

    // Current run.
    logic [rss_pkg::COLOR_W-1:0]  r_color;
    logic [rss_pkg::SPAN_W-1:0]   r_run_x;
    logic [rss_pkg::LEFT_W-1:0]   r_left;
    logic                         r_clip;
    logic                         r_last_run;

    // Output register.
    logic                             r_out_valid;
    logic [rss_pkg::OUT_TDATA_W-1:0]  r_out_data;
    logic                             r_out_last;

    logic                         div_done;
    logic [rss_pkg::SPAN_W-1:0]   div_q;
    logic [rss_pkg::SPAN_W-1:0]   div_r;

    logic                         is_start;
    logic                         is_last;
    logic [rss_pkg::ERR_W-1:0]    two_src;
    logic [rss_pkg::ERR_W-1:0]    err_a;
    logic [rss_pkg::ERR_W-1:0]    err_t;
    logic                         err_pos;
    logic [rss_pkg::ERR_W-1:0]    n_err;
    logic [rss_pkg::LEN_W-1:0]    len;
    logic                         clip;
    logic [rss_pkg::LEFT_W-1:0]   emit_n;

    rss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_dest_span),
        .i_divisor  (r_src_span),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    always_comb begin
        is_start = (r_src_idx == '0);
        is_last  = (r_src_idx >= r_src_span);
        two_src  = {1'b0, r_src_span, 1'b0};
        err_a    = '0;
        err_t    = '0;
        err_pos  = 1'b0;
        n_err    = r_err;
        if (is_start) begin
            // Line setup: the first run takes half a whole run.
            err_a = {2'b00, div_r} - two_src;
            n_err = div_q[0] ? (err_a + {2'b00, r_src_span}) : err_a;
            if (div_r == '0 && !div_q[0]) begin
                len = {2'b00, div_q[rss_pkg::SPAN_W-1:1]};
            end else begin
                len = {2'b00, div_q[rss_pkg::SPAN_W-1:1]} + 1'b1;
            end
        end else if (!is_last) begin
            err_t   = r_err + {1'b0, r_rem, 1'b0};
            err_pos = !err_t[rss_pkg::ERR_W-1] && (err_t != '0);
            n_err   = err_pos ? (err_t - two_src) : err_t;
            len     = {1'b0, r_whole} + {{(rss_pkg::LEN_W-1){1'b0}}, err_pos};
        end else begin
            len = {2'b00, r_whole[rss_pkg::SPAN_W-1:1]} + 1'b1;
        end
        clip   = (len > rss_pkg::LEN_W'(rss_pkg::MAX_RUN));
        emit_n = clip ? rss_pkg::LEFT_W'(rss_pkg::MAX_RUN) : len[rss_pkg::LEFT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_span <= rss_pkg::RST_DEST_SPAN;
            r_src_span  <= rss_pkg::RST_SRC_SPAN;
            r_transp    <= rss_pkg::RST_TRANSPARENT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                rss_pkg::CFG_DEST_SPAN:   r_dest_span <= i_cfg_wdata;
                rss_pkg::CFG_SRC_SPAN:    r_src_span  <= i_cfg_wdata;
                rss_pkg::CFG_TRANSPARENT: r_transp    <= i_cfg_wdata[rss_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= '0;
            r_src_idx   <= '0;
            r_dest_pos  <= '0;
            r_whole     <= '0;
            r_rem       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.calc) begin
                r_left <= emit_n;
                r_err  <= n_err;
                if (is_start) begin
                    r_whole    <= div_q;
                    r_rem      <= div_r;
                    r_dest_pos <= len[rss_pkg::SPAN_W-1:0];
                    r_src_idx  <= r_src_idx + 1'b1;
                end else begin
                    r_dest_pos <= r_dest_pos + len[rss_pkg::SPAN_W-1:0];
                    r_src_idx  <= is_last ? '0 : (r_src_idx + 1'b1);
                end
            end else if (i_cmd.load_out) begin
                r_left <= r_left - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_color <= i_in_color;
        end
        if (i_cmd.calc) begin
            r_run_x    <= is_start ? '0 : r_dest_pos;
            r_clip     <= clip;
            r_last_run <= is_last && !is_start;
        end else if (i_cmd.load_out) begin
            r_run_x <= r_run_x + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {1'b0, r_clip, (r_left == rss_pkg::LEFT_W'(1)), r_run_x,
                           (r_color != r_transp), r_color};
            r_out_last <= r_last_run && (r_left == rss_pkg::LEFT_W'(1));
        end
    end

    always_comb begin
        o_sts.line_start = is_start;
        o_sts.span_short = (r_src_span < rss_pkg::SPAN_W'(2));
        o_sts.div_done   = div_done;
        o_sts.left_zero  = (r_left == '0);
        o_sts.left_one   = (r_left == rss_pkg::LEFT_W'(1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

>>> hdl/rss_ctrl.sv
`timescale 1ns / 1ps

module rss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rss_pkg::t_sts   i_sts,
    output rss_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    // A line with a too short source span swallows the pixel.
                    if (i_sts.line_start && !i_sts.span_short) begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end else if (!i_sts.line_start) begin
                        n_state = S_CALC;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.left_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.left_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> hdl/run_slice_scanline_stretch_top.sv
`timescale 1ns / 1ps

// Scanline stretcher: each accepted source pixel becomes a run of destination pixels,
// one per clock when the output side is ready. A run holds at most 64 pixels and may be
// empty; the first pixel of a line also waits for the 12-bit shift-subtract divider
// that splits dest_span by src_span. A line takes src_span + 1 items. The next item is
// taken as soon as the last pixel of a run sits in the output register. The user must
// write spans through the register port only between lines, while no item is in flight;
// the block itself does not enforce this.
module run_slice_scanline_stretch_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [rss_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [rss_pkg::SPAN_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: pixel_color[7:0]
    input  logic [rss_pkg::COLOR_W-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: out_color[7:0], write_enable[8], dest_x[20:9], run_last[21],
    // run_clipped[22], zero[23]
    output logic [rss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tlast: line_last
    output logic                               m_axis_tlast
);

    rss_pkg::t_cmd cmd;
    rss_pkg::t_sts sts;

    rss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_color  (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

>>> hdl/rss_chk.sv
`timescale 1ns / 1ps

module rss_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [rss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                               m_axis_tlast
);

    logic out_hs;
    assign out_hs = m_axis_tvalid && m_axis_tready;

    // A stalled pixel holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output pixel changed while stalled");

    // The end of a line is always the end of a run.
    a_last_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[rss_pkg::OB_RUN_LAST])
        else $error("line end outside run end");

    // Inside a run the next pixel follows at once, one place further, same clip flag.
    a_run_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_hs && !m_axis_tdata[rss_pkg::OB_RUN_LAST]) |=>
        (m_axis_tvalid
         && (m_axis_tdata[rss_pkg::OB_X_LO +: rss_pkg::SPAN_W]
             == $past(m_axis_tdata[rss_pkg::OB_X_LO +: rss_pkg::SPAN_W]) + 1'b1)
         && (m_axis_tdata[rss_pkg::OB_CLIPPED] == $past(m_axis_tdata[rss_pkg::OB_CLIPPED]))))
        else $error("run pixels not contiguous");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind run_slice_scanline_stretch_top rss_chk u_rss_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
